>>> hw/rtl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the buzzer tone sequencer
// Sound phases, command codes, register indexes, sequencer states and the
// fixed tones and lengths of the built-in sequences.
// ----------------------------------------------------------------------------
package bts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CLICK  = 4'd1,
    PH_TOGGLE = 4'd2,
    PH_COIN1  = 4'd3,
    PH_COIN2  = 4'd4,
    PH_WARN1  = 4'd5,
    PH_PAUSE  = 4'd6,
    PH_WARN2  = 4'd7,
    PH_CUSTOM = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_CUSTOM        = 3'd1,
    CMD_COIN          = 3'd2,
    CMD_LOW_BATTERY   = 3'd3,
    CMD_CLICK         = 3'd4,
    CMD_TOGGLE_MASTER = 3'd5,
    CMD_TOGGLE_CLICK  = 3'd6,
    CMD_STOP          = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } seq_state_t;

  localparam int CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] REG_CLICK_FREQ   = 8'd0;
  localparam logic [CfgIndexWidth-1:0] REG_CLICK_LENGTH = 8'd1;

  localparam logic [15:0] CLICK_FREQ_RESET   = 16'd2000;
  localparam logic [7:0]  CLICK_LENGTH_RESET = 8'd5;

  // Dividend of the period computation: one second in ns.
  localparam int          PeriodWidth = 30;
  localparam logic [29:0] NS_PER_S    = 30'd1000000000;

  localparam logic [15:0] COIN1_HZ = 16'd988;
  localparam logic [15:0] COIN1_MS = 16'd65;
  localparam logic [15:0] COIN2_HZ = 16'd1319;
  localparam logic [15:0] COIN2_MS = 16'd350;
  localparam logic [15:0] WARN_HZ  = 16'd1500;
  localparam logic [15:0] WARN_MS  = 16'd100;
  localparam logic [15:0] PAUSE_MS = 16'd80;
  localparam logic [15:0] MASTER_ON_HZ  = 16'd2200;
  localparam logic [15:0] MASTER_ON_MS  = 16'd80;
  localparam logic [15:0] MASTER_OFF_HZ = 16'd1000;
  localparam logic [15:0] MASTER_OFF_MS = 16'd60;
  localparam logic [15:0] CLICK_ON_HZ   = 16'd2400;
  localparam logic [15:0] CLICK_OFF_HZ  = 16'd1200;
  localparam logic [15:0] CLICK_TOGGLE_MS = 16'd50;

endpackage

>>> hw/rtl/buzzer_tone_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_tone_sequencer_core: speaker tone sequencer with PWM timing
//
// Usage: send one item per command or 1 ms tick on the input channel
// (in_valid/in_ready). Each accepted item updates the phase, countdown, tone
// and enable flags at once, then a bit-serial restoring divider works out
// 1e9 / tone, one quotient bit per cycle in 30 steps. One result item per
// input item leaves on the output channel (out_valid/out_ready) with the
// tone, PWM period and half-period in ns and the flags after the item.
// The division runs between acceptance and the output load; a new item is
// taken only once the shared divider's result has gone to the output register.
// in_ready is high only while no division is running. The result sits in an
// output register, so a new item is taken while a result still waits; if
// the receiver stalls, a finished division holds until the register frees.
// Configuration writes (cfg_valid/cfg_ready, ready whenever out of reset) set
// the click frequency (index 0) and click length (index 1); other indexes
// are dropped.
// Reset (rst, synchronous) gives silence, an idle phase, flags from the
// parameters, click registers at 2000 Hz / 5 ms and both channels empty.
// ----------------------------------------------------------------------------
module buzzer_tone_sequencer_core
  import bts_pkg::*;
#(
  parameter bit MASTER_DEFAULT = 1'b1,
  parameter bit CLICKY_DEFAULT = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]              cfg_data,
  // input item channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               command,
  input  logic [15:0]              tone_request_hz,
  input  logic [15:0]              tone_request_ms,
  // result item channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              tone_hz,
  output logic [29:0]              pwm_period,
  output logic [28:0]              pwm_high,
  output logic                     master_on,
  output logic                     click_on,
  output logic                     playing
);

  localparam int CntWidth = $clog2(PeriodWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(PeriodWidth - 1);

  // configuration registers
  logic [15:0] click_freq_hz;
  logic [7:0]  click_length_ms;

  // sequencer state
  phase_t      sound_phase, sound_phase_next;
  logic [15:0] remaining_ms, remaining_ms_next;
  logic [15:0] current_tone_hz, current_tone_hz_next;
  logic        master_flag, master_flag_next;
  logic        click_flag, click_flag_next;

  // divider
  seq_state_t            state, state_next;
  logic [15:0]           divisor;
  logic [15:0]           rem;
  logic [29:0]           dividend;
  logic [29:0]           quot;
  logic [CntWidth-1:0]   step;
  logic [16:0]           trial;
  logic                  q_bit;

  // control strobes from the output decoder
  logic in_take;
  logic div_run;
  logic out_load;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      click_freq_hz   <= CLICK_FREQ_RESET;
      click_length_ms <= CLICK_LENGTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CLICK_FREQ) begin
        click_freq_hz <= cfg_data;
      end else if (cfg_index == REG_CLICK_LENGTH) begin
        click_length_ms <= cfg_data[7:0];
      end
    end
  end

  // Apply one item to the phase state.
  always_comb begin
    logic        in_seq;
    logic [15:0] dec_ms;
    sound_phase_next     = sound_phase;
    remaining_ms_next    = remaining_ms;
    current_tone_hz_next = current_tone_hz;
    master_flag_next     = master_flag;
    click_flag_next      = click_flag;
    in_seq = (sound_phase == PH_COIN1) || (sound_phase == PH_COIN2) ||
             (sound_phase == PH_WARN1) || (sound_phase == PH_PAUSE) ||
             (sound_phase == PH_WARN2);
    dec_ms = (remaining_ms != 16'd0) ? remaining_ms - 16'd1 : 16'd0;
    case (cmd_t'(command))
      CMD_TICK: begin
        if (sound_phase != PH_IDLE) begin
          remaining_ms_next = dec_ms;
          if (dec_ms == 16'd0) begin
            // phase ran out: advance the sequence or go silent
            case (sound_phase)
              PH_COIN1: begin
                sound_phase_next     = PH_COIN2;
                current_tone_hz_next = COIN2_HZ;
                remaining_ms_next    = COIN2_MS;
              end
              PH_WARN1: begin
                sound_phase_next     = PH_PAUSE;
                current_tone_hz_next = 16'd0;
                remaining_ms_next    = PAUSE_MS;
              end
              PH_PAUSE: begin
                sound_phase_next     = PH_WARN2;
                current_tone_hz_next = WARN_HZ;
                remaining_ms_next    = WARN_MS;
              end
              default: begin
                sound_phase_next     = PH_IDLE;
                current_tone_hz_next = 16'd0;
                remaining_ms_next    = 16'd0;
              end
            endcase
          end
        end
      end
      CMD_CUSTOM: begin
        if (master_flag) begin
          if (tone_request_hz == 16'd0 || tone_request_ms == 16'd0) begin
            sound_phase_next     = PH_IDLE;
            current_tone_hz_next = 16'd0;
            remaining_ms_next    = 16'd0;
          end else begin
            sound_phase_next     = PH_CUSTOM;
            current_tone_hz_next = tone_request_hz;
            remaining_ms_next    = tone_request_ms;
          end
        end
      end
      CMD_COIN: begin
        if (master_flag) begin
          sound_phase_next     = PH_COIN1;
          current_tone_hz_next = COIN1_HZ;
          remaining_ms_next    = COIN1_MS;
        end
      end
      CMD_LOW_BATTERY: begin
        if (master_flag) begin
          sound_phase_next     = PH_WARN1;
          current_tone_hz_next = WARN_HZ;
          remaining_ms_next    = WARN_MS;
        end
      end
      CMD_CLICK: begin
        // a click never cuts into the chime or the warning
        if (master_flag && click_flag && !in_seq) begin
          sound_phase_next     = PH_CLICK;
          current_tone_hz_next = click_freq_hz;
          remaining_ms_next    = {8'd0, click_length_ms};
        end
      end
      CMD_TOGGLE_MASTER: begin
        master_flag_next = ~master_flag;
        sound_phase_next = PH_TOGGLE;
        if (!master_flag) begin
          current_tone_hz_next = MASTER_ON_HZ;
          remaining_ms_next    = MASTER_ON_MS;
        end else begin
          current_tone_hz_next = MASTER_OFF_HZ;
          remaining_ms_next    = MASTER_OFF_MS;
        end
      end
      CMD_TOGGLE_CLICK: begin
        click_flag_next = ~click_flag;
        if (master_flag) begin
          sound_phase_next     = PH_TOGGLE;
          current_tone_hz_next = click_flag ? CLICK_OFF_HZ : CLICK_ON_HZ;
          remaining_ms_next    = CLICK_TOGGLE_MS;
        end
      end
      default: begin
        sound_phase_next     = PH_IDLE;
        current_tone_hz_next = 16'd0;
        remaining_ms_next    = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_phase     <= PH_IDLE;
      remaining_ms    <= 16'd0;
      current_tone_hz <= 16'd0;
      master_flag     <= MASTER_DEFAULT;
      click_flag      <= CLICKY_DEFAULT;
    end else if (in_take) begin
      sound_phase     <= sound_phase_next;
      remaining_ms    <= remaining_ms_next;
      current_tone_hz <= current_tone_hz_next;
      master_flag     <= master_flag_next;
      click_flag      <= click_flag_next;
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == LastStep) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: strobes.
  always_comb begin
    in_ready = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = !rst;
      ST_DIV:  div_run  = 1'b1;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring divider: shift one dividend bit into the remainder a cycle.
  assign trial = {rem, dividend[PeriodWidth-1]};
  assign q_bit = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (in_take) begin
      divisor  <= current_tone_hz_next;
      rem      <= 16'd0;
      dividend <= NS_PER_S;
      quot     <= '0;
      step     <= '0;
    end else if (div_run) begin
      rem      <= q_bit ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      dividend <= {dividend[PeriodWidth-2:0], 1'b0};
      quot     <= {quot[PeriodWidth-2:0], q_bit};
      step     <= step + CntWidth'(1);
    end
  end

  // Output register: valid is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tone_hz    <= divisor;
      // silent tone: drop the divider's all-ones answer
      pwm_period <= (divisor == 16'd0) ? 30'd0 : quot;
      pwm_high   <= (divisor == 16'd0) ? 29'd0 : quot[PeriodWidth-1:1];
      master_on  <= master_flag;
      click_on   <= click_flag;
      playing    <= (sound_phase != PH_IDLE);
    end
  end

endmodule

>>> sim/buzzer_tone_sequencer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_tone_sequencer_core_test: self-checking bench of the tone sequencer
// Walk a table of directed commands, then run phases of random command and
// tick sequences under several click register settings. A local model of
// the sequencer predicts every result item; a monitor compares the results
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module buzzer_tone_sequencer_core_test;
  import bts_pkg::*;

  typedef struct packed {
    logic [15:0] hz;
    logic [29:0] period;
    logic [28:0] pulse;
    logic        master;
    logic        click;
    logic        playing;
  } sound_t;

  // One row of the directed table; fixed rows carry a typed-in result.
  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] req_hz;
    logic [15:0] req_ms;
    logic        fixed;
    sound_t      want;
  } step_t;

  localparam int unsigned NsPerSecond  = 1000000000;
  localparam int          GapMax       = 15;
  localparam int          SettleCycles = 40;
  localparam int          PhaseItems   = 200;
  localparam int          NumPhases    = 8;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [15:0]              cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               command;
  logic [15:0]              tone_request_hz;
  logic [15:0]              tone_request_ms;
  logic                     out_valid;
  logic                     out_ready;
  logic [15:0]              tone_hz;
  logic [29:0]              pwm_period;
  logic [28:0]              pwm_high;
  logic                     master_on;
  logic                     click_on;
  logic                     playing;

  buzzer_tone_sequencer_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .tone_request_hz (tone_request_hz),
    .tone_request_ms (tone_request_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tone_hz         (tone_hz),
    .pwm_period      (pwm_period),
    .pwm_high        (pwm_high),
    .master_on       (master_on),
    .click_on        (click_on),
    .playing         (playing)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Local copy of the sequencer state and the click registers
  phase_t      m_phase;
  logic [15:0] m_left_ms;
  logic [15:0] m_tone_hz;
  logic [15:0] m_click_hz;
  logic [7:0]  m_click_ms;
  logic        m_master;
  logic        m_click_en;

  sound_t sounds_due[$];
  step_t  steps[$];
  int     mismatches;
  int     results_seen;
  logic   calm;  // no idling on either side while set

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, GapMax);
  endfunction

  function automatic void play(phase_t ph, logic [15:0] hz, logic [15:0] ms);
    m_phase   = ph;
    m_tone_hz = hz;
    m_left_ms = ms;
  endfunction

  function automatic logic in_chime_or_warning();
    return m_phase == PH_COIN1 || m_phase == PH_COIN2 || m_phase == PH_WARN1 ||
           m_phase == PH_PAUSE || m_phase == PH_WARN2;
  endfunction

  function automatic sound_t snd(logic [15:0] hz, logic [29:0] per, logic [28:0] pul,
                                 logic m, logic k, logic p);
    sound_t s;
    s.hz      = hz;
    s.period  = per;
    s.pulse   = pul;
    s.master  = m;
    s.click   = k;
    s.playing = p;
    return s;
  endfunction

  // Apply one command or tick to the local state and return the sound after it.
  function automatic sound_t next_sound(cmd_t c, logic [15:0] hz, logic [15:0] ms);
    int unsigned per;
    case (c)
      CMD_TICK: begin
        if (m_phase != PH_IDLE) begin
          if (m_left_ms != 16'd0) m_left_ms = m_left_ms - 16'd1;
          if (m_left_ms == 16'd0) begin
            // chime and warning step to their next phase, all else goes quiet
            case (m_phase)
              PH_COIN1: play(PH_COIN2, 16'd1319, 16'd350);
              PH_WARN1: play(PH_PAUSE, 16'd0, 16'd80);
              PH_PAUSE: play(PH_WARN2, 16'd1500, 16'd100);
              default:  play(PH_IDLE, 16'd0, 16'd0);
            endcase
          end
        end
      end
      CMD_CUSTOM: begin
        if (m_master) begin
          if (hz == 16'd0 || ms == 16'd0) play(PH_IDLE, 16'd0, 16'd0);
          else play(PH_CUSTOM, hz, ms);
        end
      end
      CMD_COIN: begin
        if (m_master) play(PH_COIN1, 16'd988, 16'd65);
      end
      CMD_LOW_BATTERY: begin
        if (m_master) play(PH_WARN1, 16'd1500, 16'd100);
      end
      CMD_CLICK: begin
        if (m_master && m_click_en && !in_chime_or_warning())
          play(PH_CLICK, m_click_hz, {8'd0, m_click_ms});
      end
      CMD_TOGGLE_MASTER: begin
        m_master = !m_master;
        if (m_master) play(PH_TOGGLE, 16'd2200, 16'd80);
        else play(PH_TOGGLE, 16'd1000, 16'd60);
      end
      CMD_TOGGLE_CLICK: begin
        m_click_en = !m_click_en;
        if (m_master) play(PH_TOGGLE, m_click_en ? 16'd2400 : 16'd1200, 16'd50);
      end
      default: play(PH_IDLE, 16'd0, 16'd0);
    endcase
    per = (m_tone_hz == 16'd0) ? 0 : NsPerSecond / m_tone_hz;
    return snd(m_tone_hz, per[29:0], per[29:1], m_master, m_click_en, m_phase != PH_IDLE);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t: result %0d: %s", $time, results_seen, what);
  endtask

  // Hold valid until taken; keep it high across back-to-back items.
  task automatic send(cmd_t c, logic [15:0] hz, logic [15:0] ms, logic fixed,
                      sound_t want);
    int     gap;
    sound_t s;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= c;
    tone_request_hz <= hz;
    tone_request_ms <= ms;
    do @(posedge clk); while (!in_ready);
    s = next_sound(c, hz, ms);
    sounds_due.push_back(fixed ? want : s);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CLICK_FREQ) m_click_hz = data;
    else if (idx == REG_CLICK_LENGTH) m_click_ms = data[7:0];
    @(posedge clk);
  endtask

  task automatic drain();
    while (sounds_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles before taking each result item.
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result item against the oldest predicted sound.
  always @(posedge clk) begin : result_check
    sound_t want;
    if (!rst && out_valid && out_ready) begin
      if (sounds_due.size() == 0) begin
        report_mismatch("result item with nothing pending");
      end else begin
        want = sounds_due.pop_front();
        if (tone_hz !== want.hz)
          report_mismatch($sformatf("tone_hz %0d, want %0d", tone_hz, want.hz));
        if (pwm_period !== want.period)
          report_mismatch($sformatf("pwm_period %0d, want %0d", pwm_period, want.period));
        if (pwm_high !== want.pulse)
          report_mismatch($sformatf("pwm_high %0d, want %0d", pwm_high, want.pulse));
        if (master_on !== want.master)
          report_mismatch($sformatf("master_on %0b, want %0b", master_on, want.master));
        if (click_on !== want.click)
          report_mismatch($sformatf("click_on %0b, want %0b", click_on, want.click));
        if (playing !== want.playing)
          report_mismatch($sformatf("playing %0b, want %0b", playing, want.playing));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int          items;
    int          r;
    int          n;
    cmd_t        c;
    logic [15:0] hz;
    logic [15:0] ms;
    logic [15:0] f;
    logic [7:0]  l;
    logic [7:0]  up;
    logic [CfgIndexWidth-1:0] junk;

    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    command         <= CMD_TICK;
    tone_request_hz <= '0;
    tone_request_ms <= '0;
    calm         = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    m_click_hz   = 16'd2000;
    m_click_ms   = 8'd5;
    m_master     = 1'b1;
    m_click_en   = 1'b1;
    play(PH_IDLE, 16'd0, 16'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, reset register values
    steps.push_back('{CMD_TICK, 16'hffff, 16'hffff, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});
    // highest frequency for a single ms, then let it run out
    steps.push_back('{CMD_CUSTOM, 16'hffff, 16'd1, 1'b1,
                      snd(16'hffff, 30'd15259, 29'd7629, 1'b1, 1'b1, 1'b1)});
    steps.push_back('{CMD_TICK, 16'd0, 16'd0, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});
    // lowest frequency gives the longest period
    steps.push_back('{CMD_CUSTOM, 16'd1, 16'hffff, 1'b1,
                      snd(16'd1, 30'd1000000000, 29'd500000000, 1'b1, 1'b1, 1'b1)});
    // zero frequency or zero length acts as stop
    steps.push_back('{CMD_CUSTOM, 16'd0, 16'd100, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});
    steps.push_back('{CMD_CUSTOM, 16'd440, 16'd3, 1'b0, '0});
    steps.push_back('{CMD_CUSTOM, 16'd500, 16'd0, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});
    // a click never cuts into the chime or the warning
    steps.push_back('{CMD_COIN, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_TICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_LOW_BATTERY, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_STOP, 16'hffff, 16'hffff, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});
    steps.push_back('{CMD_CLICK, 16'd0, 16'd0, 1'b0, '0});
    // click toggles, with a click while clicks are off
    steps.push_back('{CMD_TOGGLE_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_TOGGLE_CLICK, 16'd0, 16'd0, 1'b0, '0});
    // master off drops every sound command
    steps.push_back('{CMD_TOGGLE_MASTER, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_CUSTOM, 16'd1234, 16'd10, 1'b0, '0});
    steps.push_back('{CMD_COIN, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_LOW_BATTERY, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_TOGGLE_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_STOP, 16'd0, 16'd0, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b0, 1'b0, 1'b0)});
    steps.push_back('{CMD_TOGGLE_CLICK, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_TOGGLE_MASTER, 16'd0, 16'd0, 1'b0, '0});
    steps.push_back('{CMD_STOP, 16'd0, 16'd0, 1'b1,
                      snd(16'd0, 30'd0, 29'd0, 1'b1, 1'b1, 1'b0)});

    foreach (steps[i]) send(steps[i].cmd, steps[i].req_hz, steps[i].req_ms,
                            steps[i].fixed, steps[i].want);
    in_valid <= 1'b0;
    drain();

    // Random phases, each under its own click register setting
    for (int p = 0; p < NumPhases; p++) begin
      calm = (p == 2) || (p == 5);
      case (p)
        0: begin f = 16'd2000; l = 8'd5;   end
        1: begin f = 16'd0;    l = 8'd0;   end  // silent click that ends at once
        2: begin f = 16'd1;    l = 8'd1;   end
        3: begin f = 16'hffff; l = 8'hff;  end
        default: begin
          f = 16'($urandom);
          l = 8'($urandom_range(0, 40));
        end
      endcase
      up   = 8'($urandom);
      junk = CfgIndexWidth'($urandom_range(2, 255));
      write_reg(junk, 16'($urandom));  // unknown index, drop
      write_reg(REG_CLICK_FREQ, f);
      write_reg(REG_CLICK_LENGTH, {up, l});

      items = 0;
      while (items < PhaseItems) begin
        r  = $urandom_range(0, 99);
        hz = 16'($urandom);
        ms = 16'($urandom);
        if (!m_master && r < 50) c = CMD_TOGGLE_MASTER;
        else if (r < 20) c = CMD_CUSTOM;
        else if (r < 30) c = CMD_COIN;
        else if (r < 40) c = CMD_LOW_BATTERY;
        else if (r < 62) c = CMD_CLICK;
        else if (r < 70) c = CMD_TOGGLE_MASTER;
        else if (r < 78) c = CMD_TOGGLE_CLICK;
        else if (r < 85) c = CMD_STOP;
        else c = CMD_TICK;
        if (c == CMD_CUSTOM) begin
          case ($urandom_range(0, 9))
            0: hz = 16'd0;
            1: hz = 16'hffff;
            2: hz = 16'd1;
            default: ;
          endcase
          case ($urandom_range(0, 9))
            0: ms = 16'd0;
            1: ms = 16'hffff;
            2, 3, 4, 5, 6: ms = 16'($urandom_range(1, 40));
            default: ;
          endcase
        end
        send(c, hz, ms, 1'b0, '0);
        items++;

        // Follow with a run of ticks; chime and warning often play out fully
        if ((c == CMD_COIN || c == CMD_LOW_BATTERY) && $urandom_range(0, 2) == 0)
          n = $urandom_range(60, 430);
        else if ($urandom_range(0, 3) == 0)
          n = $urandom_range(10, 90);
        else
          n = $urandom_range(0, 6);
        repeat (n) begin
          send(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
          items++;
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/bts_pkg.sv
hw/rtl/buzzer_tone_sequencer_core.sv
sim/buzzer_tone_sequencer_core_test.sv
